### design/rciobd_pkg.sv
// shared types, codes and constants of the retro cpu io and bank decoder
package rciobd_pkg;

    localparam int KEY_DEPTH_DEFAULT = 8;
    localparam int KEY_WIDTH         = 8;

    // field widths
    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 32;
    localparam int REQ_W    = 3;
    localparam int PEND_W   = 16;

    // stream widths
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 3;

    // commands
    localparam logic [CMD_W-1:0] CMD_MEM_READ = 2'd0;
    localparam logic [CMD_W-1:0] CMD_IO_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_IO_WRITE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd3;

    // bus requests
    localparam logic [REQ_W-1:0] REQ_NONE       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CONSOLE_WR = 3'd1;
    localparam logic [REQ_W-1:0] REQ_IDE_RD     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_IDE_WR     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_HOST_RD    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_HOST_WR    = 3'd5;

    // io ports
    localparam logic [BYTE_W-1:0] PORT_ROM_OFF    = 8'h38;
    localparam logic [BYTE_W-1:0] PORT_BANK_HIGH  = 8'h3E;
    localparam logic [BYTE_W-1:0] PORT_BANK_LOW   = 8'h3F;
    localparam logic [BYTE_W-1:0] PORT_HOST_BYTE1 = 8'h41;
    localparam logic [BYTE_W-1:0] PORT_HOST_BYTE2 = 8'h42;
    localparam logic [BYTE_W-1:0] PORT_HOST_BYTE3 = 8'h43;

    // constants of the map
    localparam logic [ADDR_W-1:0] RAM_BASE       = 16'h4000;
    localparam logic [WORD_W-1:0] HOST_BASE      = 32'hBF800000;
    localparam logic [BYTE_W-1:0] STATUS_BASE    = 8'h06;
    localparam logic [PEND_W-1:0] PEND_MAX       = 16'hFFFF;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] write_data;
        logic [WORD_W-1:0] external_word;
        logic [BYTE_W-1:0] key_char;
        logic              timer_due;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              mem_is_rom;
        logic [ADDR_W-1:0] mem_address;
        logic [REQ_W-1:0]  bus_request;
        logic [WORD_W-1:0] bus_address;
        logic [WORD_W-1:0] bus_write_data;
        logic              interrupt_request;
    } result_t;

endpackage

### design/rciobd_ram.sv
// generic single-write, single-read ram with registered read data
module rciobd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### design/rciobd_core.sv
// decode of one transaction and the latches, key ring and timer state it updates
module rciobd_core #(
    parameter int KEY_DEPTH = rciobd_pkg::KEY_DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  rciobd_pkg::item_t   item,
    output rciobd_pkg::result_t result
);

    localparam int IW = $clog2(KEY_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(KEY_DEPTH - 1);

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
        ring_next = (i == LAST_IDX) ? '0 : i + IW'(1);
    endfunction

    logic                           rom_disabled_reg, rom_disabled_next;
    logic                           bank_low_reg, bank_low_next;
    logic                           bank_high_reg, bank_high_next;
    logic [IW-1:0]                  wr_idx_reg, wr_idx_next;
    logic [IW-1:0]                  rd_idx_reg, rd_idx_next;
    logic [rciobd_pkg::BYTE_W-1:0]  prev_key_reg, prev_key_next;
    logic [rciobd_pkg::PEND_W-1:0]  pending_reg, pending_next;
    logic                           square_reg, square_next;
    logic [rciobd_pkg::WORD_W-1:0]  host_word_reg, host_word_next;
    logic                           bypass_reg, bypass_next;
    logic [rciobd_pkg::KEY_WIDTH-1:0] bypass_data_reg;

    logic                           ring_we;
    logic [rciobd_pkg::KEY_WIDTH-1:0] ram_q;
    logic [rciobd_pkg::KEY_WIDTH-1:0] ring_head;
    logic                           not_empty;
    logic [rciobd_pkg::BYTE_W-1:0]  port;
    logic [rciobd_pkg::BYTE_W-1:0]  high;
    logic [rciobd_pkg::WORD_W-1:0]  host_addr;
    logic                           is_serial, is_ide, is_host_byte;
    logic [rciobd_pkg::PEND_W-1:0]  pend_tick;

    rciobd_ram #(
        .WIDTH (rciobd_pkg::KEY_WIDTH),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (ring_we),
        .wr_addr (wr_idx_reg),
        .wr_data (item.key_char),
        .rd_addr (rd_idx_next),
        .rd_data (ram_q)
    );

    // same-cycle write to the entry being fetched is forwarded
    assign bypass_next = ring_we && (wr_idx_reg == rd_idx_next);
    assign ring_head   = bypass_reg ? bypass_data_reg : ram_q;
    assign not_empty   = (rd_idx_reg != wr_idx_reg);

    assign port         = item.address[7:0];
    assign high         = item.address[15:8];
    assign host_addr    = rciobd_pkg::HOST_BASE
                        | {12'b0, port[6], 3'b0, high, port[5:0], 2'b0};
    assign is_serial    = (port[7:3] == 5'b00000);
    assign is_ide       = (port[7:3] == 5'b00010);
    assign is_host_byte = (port == rciobd_pkg::PORT_HOST_BYTE1)
                       || (port == rciobd_pkg::PORT_HOST_BYTE2)
                       || (port == rciobd_pkg::PORT_HOST_BYTE3);
    assign pend_tick    = (item.timer_due && (pending_reg != rciobd_pkg::PEND_MAX))
                        ? pending_reg + 16'd1 : pending_reg;

    always_comb begin
        rom_disabled_next = rom_disabled_reg;
        bank_low_next     = bank_low_reg;
        bank_high_next    = bank_high_reg;
        wr_idx_next       = wr_idx_reg;
        rd_idx_next       = rd_idx_reg;
        prev_key_next     = prev_key_reg;
        pending_next      = pending_reg;
        square_next       = square_reg;
        host_word_next    = host_word_reg;
        ring_we           = 1'b0;
        result            = '0;

        unique case (item.command)
            rciobd_pkg::CMD_MEM_READ: begin
                if (item.address >= rciobd_pkg::RAM_BASE || rom_disabled_reg) begin
                    result.mem_address = item.address;
                end else begin
                    result.mem_is_rom  = 1'b1;
                    result.mem_address = item.address
                                       + {bank_high_reg, bank_low_reg, 14'b0};
                end
            end
            rciobd_pkg::CMD_IO_READ: begin
                if (is_serial) begin
                    if (!port[1]) begin
                        if (not_empty) begin
                            result.read_data = ring_head;
                            rd_idx_next      = ring_next(rd_idx_reg);
                        end
                    end else begin
                        if (pending_reg != '0) begin
                            pending_next = pending_reg - 16'd1;
                            square_next  = ~square_reg;
                        end
                        result.read_data = rciobd_pkg::STATUS_BASE
                                         | {4'b0, square_next, 2'b0, not_empty};
                    end
                end else if (is_ide) begin
                    result.bus_request = rciobd_pkg::REQ_IDE_RD;
                    result.bus_address = {29'b0, port[2:0]};
                    result.read_data   = item.external_word[7:0];
                end else if (is_host_byte) begin
                    unique case (port[1:0])
                        2'b01:   result.read_data = host_word_reg[15:8];
                        2'b10:   result.read_data = host_word_reg[23:16];
                        default: result.read_data = host_word_reg[31:24];
                    endcase
                end else if (port[7]) begin
                    result.bus_request = rciobd_pkg::REQ_HOST_RD;
                    result.bus_address = host_addr;
                    host_word_next     = item.external_word;
                    result.read_data   = item.external_word[7:0];
                end
            end
            rciobd_pkg::CMD_IO_WRITE: begin
                if (is_serial) begin
                    if (!port[1]) begin
                        result.bus_request    = rciobd_pkg::REQ_CONSOLE_WR;
                        result.bus_write_data = {24'b0, item.write_data};
                    end
                end else if (is_ide) begin
                    result.bus_request    = rciobd_pkg::REQ_IDE_WR;
                    result.bus_address    = {29'b0, port[2:0]};
                    result.bus_write_data = {24'b0, item.write_data};
                end else if (port == rciobd_pkg::PORT_ROM_OFF) begin
                    rom_disabled_next = item.write_data[0];
                end else if (port == rciobd_pkg::PORT_BANK_HIGH) begin
                    bank_high_next = item.write_data[0];
                end else if (port == rciobd_pkg::PORT_BANK_LOW) begin
                    bank_low_next = item.write_data[0];
                end else if (port == rciobd_pkg::PORT_HOST_BYTE1) begin
                    host_word_next = {host_word_reg[31:16], item.write_data, 8'h00};
                end else if (port == rciobd_pkg::PORT_HOST_BYTE2) begin
                    host_word_next = {host_word_reg[31:24], item.write_data,
                                      host_word_reg[15:8], 8'h00};
                end else if (port == rciobd_pkg::PORT_HOST_BYTE3) begin
                    host_word_next = {item.write_data, host_word_reg[23:8], 8'h00};
                end else if (port[7]) begin
                    host_word_next        = {host_word_reg[31:8], item.write_data};
                    result.bus_request    = rciobd_pkg::REQ_HOST_WR;
                    result.bus_address    = host_addr;
                    result.bus_write_data = host_word_next;
                end
            end
            default: begin
                // periodic tick
                if (item.key_char != '0 && item.key_char != prev_key_reg) begin
                    ring_we                  = 1'b1;
                    wr_idx_next              = ring_next(wr_idx_reg);
                    result.interrupt_request = 1'b1;
                end
                prev_key_next = item.key_char;
                pending_next  = pend_tick;
                if (pend_tick != '0) begin
                    result.interrupt_request = 1'b1;
                end
            end
        endcase

        if (!step) begin
            ring_we     = 1'b0;
            rd_idx_next = rd_idx_reg;
            wr_idx_next = wr_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_disabled_reg <= 1'b0;
            bank_low_reg     <= 1'b0;
            bank_high_reg    <= 1'b0;
            wr_idx_reg       <= '0;
            rd_idx_reg       <= '0;
            prev_key_reg     <= '0;
            pending_reg      <= '0;
            square_reg       <= 1'b0;
            host_word_reg    <= '0;
            bypass_reg       <= 1'b0;
        end else begin
            bypass_reg <= bypass_next;
            if (step) begin
                rom_disabled_reg <= rom_disabled_next;
                bank_low_reg     <= bank_low_next;
                bank_high_reg    <= bank_high_next;
                wr_idx_reg       <= wr_idx_next;
                rd_idx_reg       <= rd_idx_next;
                prev_key_reg     <= prev_key_next;
                pending_reg      <= pending_next;
                square_reg       <= square_next;
                host_word_reg    <= host_word_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        bypass_data_reg <= item.key_char;
    end

endmodule

### design/retro_cpu_io_and_bank_decoder_top.sv
// top level of the retro cpu io and bank decoder: stream ports, input and result registers
// One transaction in, one transaction out. Each accepted item (memory read, io read,
// io write or periodic tick) is held in an input register, decoded combinationally
// against the bank latches, key ring, timer counter and host word, and the result
// lands in a result register. The block accepts one item per clock while m_tready
// does not stall a full result register, and returns one result per item in order;
// each item passes the input register and then the result register. The rate is
// set by the combinational decode and state update loop; the key ring sits in a
// small ram whose head entry is fetched ahead, so ring reads wait on no ram access.
// No clearing pass is needed after reset.
module retro_cpu_io_and_bank_decoder_top #(
    parameter int KEY_DEPTH = rciobd_pkg::KEY_DEPTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // address[15:0], write_data[23:16], external_word[55:24], key_char[63:56],
    // timer_due[64], zero fill above
    input  logic [rciobd_pkg::S_TDATA_W-1:0] s_tdata,
    // command[1:0]
    input  logic [rciobd_pkg::S_TUSER_W-1:0] s_tuser,
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // read_data[7:0], mem_is_rom[8], mem_address[24:9], bus_address[56:25],
    // bus_write_data[88:57], interrupt_request[89], zero fill above
    output logic [rciobd_pkg::M_TDATA_W-1:0] m_tdata,
    // bus_request[2:0]
    output logic [rciobd_pkg::M_TUSER_W-1:0] m_tuser
);

    logic                in_valid_reg, in_valid_next;
    rciobd_pkg::item_t   in_item_reg;
    logic                out_valid_reg, out_valid_next;
    rciobd_pkg::result_t out_result_reg;
    rciobd_pkg::result_t core_result;
    logic                advance;
    logic                step;
    logic                s_accept;

    // the result register frees when empty or when its transaction is taken
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    rciobd_core #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.command       <= s_tuser[1:0];
            in_item_reg.address       <= s_tdata[15:0];
            in_item_reg.write_data    <= s_tdata[23:16];
            in_item_reg.external_word <= s_tdata[55:24];
            in_item_reg.key_char      <= s_tdata[63:56];
            in_item_reg.timer_due     <= s_tdata[64];
        end
        if (step) begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.bus_request;
    assign m_tdata  = {6'b0,
                       out_result_reg.interrupt_request,
                       out_result_reg.bus_write_data,
                       out_result_reg.bus_address,
                       out_result_reg.mem_address,
                       out_result_reg.mem_is_rom,
                       out_result_reg.read_data};

endmodule
